>>> src/prcd_pkg.sv
package prcd_pkg;

    // Default number of PPM channels in a frame
    localparam int NUM_CHANNELS_DEF = 8;

    // Request kinds carried on the input tuser bit
    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_VALID_MIN = 3'd0,
        CFG_VALID_MAX = 3'd1,
        CFG_SYNC_GAP  = 3'd2,
        CFG_DEADBAND  = 3'd3,
        CFG_ARM_THR   = 3'd4
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register widths and reset values
    localparam int VMIN_W   = 12;
    localparam int VMAX_W   = 12;
    localparam int SYNC_W   = 16;
    localparam int DB_W     = 9;
    localparam int ARM_W    = 12;
    localparam int VMIN_RST = 990;
    localparam int VMAX_RST = 2010;
    localparam int SYNC_RST = 2010;
    localparam int DB_RST   = 50;
    localparam int ARM_RST  = 1500;

    // Stream field widths
    localparam int TIME_W      = 16;
    localparam int TICK_W      = 16;
    localparam int ROLL_W      = 14;
    localparam int PITCH_W     = 14;
    localparam int THR_W       = 16;
    localparam int YAW_W       = 17;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = ROLL_W + PITCH_W + THR_W + YAW_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Stored width: a kept width never exceeds the 12-bit valid window bound
    localparam int WID_W = 12;

    // Gap check: 16-bit tick difference times 1000
    localparam int US_PER_MS = 1000;
    localparam int GAP_W     = 26;

    // Command mapping
    localparam int CENTRE_US  = 1500;
    localparam int RAW_MIN_US = 1000;
    localparam int RAW_MAX_US = 2000;
    localparam int D_W        = 10;
    localparam int X_W        = 22;
    localparam int MUL_RP     = 256;
    localparam int MUL_THR    = 1152;
    localparam int MUL_YAW    = 2304;
    localparam int ROUND_BIAS = 12;
    // floor(x / 25) == (x * RECIP_MUL) >> RECIP_SHIFT for x below 2^26 / 11
    localparam int RECIP_MUL   = 2684355;
    localparam int RECIP_SHIFT = 26;
    localparam int PROD_W      = 44;
    localparam int Q_W         = 17;
    localparam int OFS_RP      = 5120;
    localparam int OFS_YAW     = 46080;
    localparam int THR_MAX     = 46080;

    // Pre-scaled values handed from the lookup stage to the divide stage
    typedef struct packed {
        logic [X_W-1:0] roll_x;
        logic [X_W-1:0] pitch_x;
        logic [X_W-1:0] thr_x;
        logic [X_W-1:0] yaw_x;
        logic           armed;
    } scaled_t;

endpackage

>>> src/ppm_rc_command_decoder.sv
// Edge items: decoder state updated from the input register the cycle after acceptance; no result.
// Read items: result on m_axis after passing the input register, the channel lookup
// and pre-scale register, and the reciprocal divide-by-25 output register.
// Throughput: one item per cycle; a waiting result stalls the input only once a read
// is held behind it.
// Reset (rst_n, async low): channel widths, edge counter and timestamps
// clear to zero, configuration returns to 990/2010/2010/50/1500.
module ppm_rc_command_decoder #(
    parameter int NUM_CHANNELS = prcd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] capture_time, [31:16] tick_ms
    input  logic [prcd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] req_type
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [13:0] roll_cmd, [27:14] pitch_cmd, [43:28] throttle_cmd,
    // [60:44] yaw_rate_cmd, [61] armed, [63:62] zero
    output logic [prcd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [prcd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [prcd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import prcd_pkg::*;

    localparam int EC_W = $clog2(NUM_CHANNELS + 2);
    localparam int CH_W = $clog2(NUM_CHANNELS);

    // Configuration
    logic [VMIN_W-1:0] valid_min_reg;
    logic [VMAX_W-1:0] valid_max_reg;
    logic [SYNC_W-1:0] sync_gap_reg;
    logic [DB_W-1:0]   deadband_reg;
    logic [ARM_W-1:0]  arm_thr_reg;

    // Input register
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              in_req_reg;
    logic [TIME_W-1:0] in_cap_reg;
    logic [TICK_W-1:0] in_tick_reg;

    // Decoder state
    logic [TIME_W-1:0] prev_edge_reg;
    logic [TICK_W-1:0] prev_tick_reg;
    logic [EC_W-1:0]   edge_count_reg;
    logic [EC_W-1:0]   edge_count_next;
    logic [WID_W-1:0]  chan_reg [NUM_CHANNELS];

    // Pipeline
    logic                   x_valid_reg;
    logic                   x_valid_next;
    scaled_t                x_reg;
    scaled_t                x_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic [OUT_TDATA_W-1:0] m_data_next;

    // Handshake
    logic s_accept;
    logic out_ready;
    logic x_ready;
    logic edge_fire;
    logic rd_fire;
    logic in_done;

    // Edge path
    logic [TIME_W-1:0] cap_diff;
    logic              width_ok;
    logic              ch_live;
    logic [EC_W-1:0]   ch_idx_full;
    logic [CH_W-1:0]   ch_idx;
    logic [TICK_W-1:0] tick_gap;
    logic [GAP_W-1:0]  gap_us;
    logic              sync_hit;

    // Divide stage
    logic [PROD_W-1:0] prod_roll;
    logic [PROD_W-1:0] prod_pitch;
    logic [PROD_W-1:0] prod_thr;
    logic [PROD_W-1:0] prod_yaw;
    logic [Q_W-1:0]    q_roll;
    logic [Q_W-1:0]    q_pitch;
    logic [Q_W-1:0]    q_thr;
    logic [Q_W-1:0]    q_yaw;
    logic [Q_W-1:0]    roll_full;
    logic [Q_W-1:0]    pitch_full;
    logic [Q_W-1:0]    yaw_full;

    // Snap into the deadband if asked, clamp to 1000..2000, remove the offset
    function automatic logic [D_W-1:0] to_offset(input logic [WID_W-1:0] w,
                                                 input logic snap_en,
                                                 input logic [DB_W-1:0] db);
        logic [WID_W-1:0] dev;
        logic [WID_W-1:0] ws;
        logic [WID_W-1:0] wc;
        dev = (w >= WID_W'(CENTRE_US)) ? (w - WID_W'(CENTRE_US))
                                       : (WID_W'(CENTRE_US) - w);
        ws = (snap_en && (dev <= WID_W'(db))) ? WID_W'(CENTRE_US) : w;
        if (ws < WID_W'(RAW_MIN_US)) begin
            wc = WID_W'(RAW_MIN_US);
        end else if (ws > WID_W'(RAW_MAX_US)) begin
            wc = WID_W'(RAW_MAX_US);
        end else begin
            wc = ws;
        end
        return D_W'(wc - WID_W'(RAW_MIN_US));
    endfunction

    // d * mul + rounding bias, ahead of the divide by 25
    function automatic logic [X_W-1:0] pre_scale(input logic [D_W-1:0] d,
                                                 input logic [X_W-1:0] mul);
        return X_W'(d) * mul + X_W'(ROUND_BIAS);
    endfunction

    // Handshake
    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign x_ready       = !x_valid_reg || out_ready;
    assign edge_fire     = in_valid_reg && (in_req_reg == REQ_EDGE);
    assign rd_fire       = in_valid_reg && (in_req_reg == REQ_READ) && x_ready;
    assign in_done       = edge_fire || rd_fire;
    assign s_axis_tready = !in_valid_reg || in_done;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_valid_next = s_accept || (in_valid_reg && !in_done);
    assign x_valid_next  = rd_fire || (x_valid_reg && !out_ready);
    assign m_valid_next  = (x_valid_reg && out_ready) || (m_valid_reg && !m_axis_tready);

    // Edge path
    always_comb
    begin
        cap_diff    = in_cap_reg - prev_edge_reg;
        width_ok    = (cap_diff >= TIME_W'(valid_min_reg)) &&
                      (cap_diff <= TIME_W'(valid_max_reg));
        ch_live     = (edge_count_reg != '0) &&
                      (edge_count_reg <= EC_W'(NUM_CHANNELS));
        ch_idx_full = edge_count_reg - EC_W'(1);
        ch_idx      = ch_idx_full[CH_W-1:0];
        tick_gap    = in_tick_reg - prev_tick_reg;
        gap_us      = GAP_W'(tick_gap) * GAP_W'(US_PER_MS);
        sync_hit    = gap_us > GAP_W'(sync_gap_reg);
        if (sync_hit) begin
            edge_count_next = EC_W'(1);
        end else if (edge_count_reg < EC_W'(NUM_CHANNELS + 1)) begin
            edge_count_next = edge_count_reg + EC_W'(1);
        end else begin
            edge_count_next = edge_count_reg;
        end
    end

    // Lookup and pre-scale for a read
    always_comb
    begin
        x_next.roll_x  = pre_scale(to_offset(chan_reg[0], 1'b1, deadband_reg),
                                   X_W'(MUL_RP));
        x_next.pitch_x = pre_scale(to_offset(chan_reg[1], 1'b1, deadband_reg),
                                   X_W'(MUL_RP));
        x_next.thr_x   = pre_scale(to_offset(chan_reg[2], 1'b0, deadband_reg),
                                   X_W'(MUL_THR));
        x_next.yaw_x   = pre_scale(to_offset(chan_reg[3], 1'b1, deadband_reg),
                                   X_W'(MUL_YAW));
        x_next.armed   = chan_reg[6] >= arm_thr_reg;
    end

    // Divide by 25 through the reciprocal, then center roll, pitch and yaw
    always_comb
    begin
        prod_roll   = PROD_W'(x_reg.roll_x) * PROD_W'(RECIP_MUL);
        prod_pitch  = PROD_W'(x_reg.pitch_x) * PROD_W'(RECIP_MUL);
        prod_thr    = PROD_W'(x_reg.thr_x) * PROD_W'(RECIP_MUL);
        prod_yaw    = PROD_W'(x_reg.yaw_x) * PROD_W'(RECIP_MUL);
        q_roll      = prod_roll[RECIP_SHIFT +: Q_W];
        q_pitch     = prod_pitch[RECIP_SHIFT +: Q_W];
        q_thr       = prod_thr[RECIP_SHIFT +: Q_W];
        q_yaw       = prod_yaw[RECIP_SHIFT +: Q_W];
        roll_full   = q_roll - Q_W'(OFS_RP);
        pitch_full  = q_pitch - Q_W'(OFS_RP);
        yaw_full    = q_yaw - Q_W'(OFS_YAW);
        m_data_next = {(OUT_TDATA_W - OUT_FIELD_W)'(0), x_reg.armed, yaw_full[YAW_W-1:0],
                       q_thr[THR_W-1:0], pitch_full[PITCH_W-1:0],
                       roll_full[ROLL_W-1:0]};
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_min_reg <= VMIN_W'(VMIN_RST);
            valid_max_reg <= VMAX_W'(VMAX_RST);
            sync_gap_reg  <= SYNC_W'(SYNC_RST);
            deadband_reg  <= DB_W'(DB_RST);
            arm_thr_reg   <= ARM_W'(ARM_RST);
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_VALID_MIN: valid_min_reg <= cfg_data[VMIN_W-1:0];
                CFG_VALID_MAX: valid_max_reg <= cfg_data[VMAX_W-1:0];
                CFG_SYNC_GAP:  sync_gap_reg  <= cfg_data[SYNC_W-1:0];
                CFG_DEADBAND:  deadband_reg  <= cfg_data[DB_W-1:0];
                CFG_ARM_THR:   arm_thr_reg   <= cfg_data[ARM_W-1:0];
                default:       ;
            endcase
        end
    end

    // Control and decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg   <= 1'b0;
            x_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            prev_edge_reg  <= '0;
            prev_tick_reg  <= '0;
            edge_count_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                chan_reg[i] <= '0;
            end
        end else begin
            in_valid_reg <= in_valid_next;
            x_valid_reg  <= x_valid_next;
            m_valid_reg  <= m_valid_next;
            if (edge_fire) begin
                if (ch_live && width_ok) begin
                    chan_reg[ch_idx] <= cap_diff[WID_W-1:0];
                end
                edge_count_reg <= edge_count_next;
                prev_edge_reg  <= in_cap_reg;
                prev_tick_reg  <= in_tick_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept) begin
            in_req_reg  <= s_axis_tuser;
            in_cap_reg  <= s_axis_tdata[TIME_W-1:0];
            in_tick_reg <= s_axis_tdata[TIME_W +: TICK_W];
        end
        if (rd_fire) begin
            x_reg <= x_next;
        end
        if (x_valid_reg && out_ready) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

>>> src/prcd_checker.sv
module prcd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               s_axis_tuser,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [prcd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import prcd_pkg::*;

    logic rd_accept;

    assign rd_accept = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_READ);

    // A stalled result stays presented
    a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its data
    a_m_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // A read reaches the output through the input, pre-scale and divide registers when the sink keeps up
    a_rd_latency: assert property (@(posedge clk) disable iff (!rst_n)
        rd_accept ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("read result late");

    // Commands stay inside their mapped ranges
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[13:0]) >= -14'sd5120) &&
            ($signed(m_axis_tdata[13:0]) <= 14'sd5120) &&
            ($signed(m_axis_tdata[27:14]) >= -14'sd5120) &&
            ($signed(m_axis_tdata[27:14]) <= 14'sd5120) &&
            (m_axis_tdata[43:28] <= 16'(THR_MAX)) &&
            ($signed(m_axis_tdata[60:44]) >= -17'sd46080) &&
            ($signed(m_axis_tdata[60:44]) <= 17'sd46080) &&
            (m_axis_tdata[63:62] == 2'b00))
        else $error("command out of range");

endmodule

bind ppm_rc_command_decoder prcd_checker u_prcd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import prcd_pkg::*;

    localparam int NCH         = NUM_CHANNELS_DEF;
    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_ITEMS = 1700;

    // Command fields, roll in the lowest bits as on m_axis_tdata
    typedef struct packed {
        logic              armed;
        logic [YAW_W-1:0]  yaw;
        logic [THR_W-1:0]  thr;
        logic [PITCH_W-1:0] pitch;
        logic [ROLL_W-1:0] roll;
    } cmd_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;   // [15:0] capture_time, [31:16] tick_ms
    logic                    s_axis_tuser = 1'b0; // [0] req_type
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;        // roll, pitch, throttle, yaw, armed, pad
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    ppm_rc_command_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder model: configuration and frame state
    logic [11:0] win_lo     = 12'(VMIN_RST);
    logic [11:0] win_hi     = 12'(VMAX_RST);
    logic [15:0] sync_limit = 16'(SYNC_RST);
    logic [8:0]  dead_band  = 9'(DB_RST);
    logic [11:0] arm_level  = 12'(ARM_RST);
    logic [15:0] last_cap   = '0;
    logic [15:0] last_tick  = '0;
    logic [3:0]  edge_pos   = '0;
    logic [15:0] chan_us [NCH];

    cmd_t pending_cmds [$];

    // Stimulus side: timer values of the last edge sent
    logic [15:0] cap_now  = '0;
    logic [15:0] tick_now = '0;

    bit rush = 1'b0;
    int sink_wait = 0;
    int faults = 0;
    int items_sent = 0;
    int reads_sent = 0;
    int cmds_checked = 0;
    int settings_used = 0;
    int cycle_count = 0;

    initial
    begin
        foreach (chan_us[i])
            chan_us[i] = '0;
    end

    function automatic void ppm_edge_update(input logic [15:0] cap, input logic [15:0] tick);
        logic [15:0] w;
        logic [15:0] dt;
        if (edge_pos >= 1 && edge_pos <= NCH)
        begin
            w = cap - last_cap;
            if (w >= win_lo && w <= win_hi)
                chan_us[edge_pos - 1] = w;
        end
        if (edge_pos < NCH + 1)
            edge_pos++;
        last_cap = cap;
        dt = tick - last_tick;
        // full-width product, no truncation to 16 bits
        if (int'(dt) * US_PER_MS > int'(sync_limit))
            edge_pos = 1;
        last_tick = tick;
    endfunction

    function automatic int snap_centre(input int w);
        int dev;
        dev = (w >= CENTRE_US) ? w - CENTRE_US : CENTRE_US - w;
        return (dev <= int'(dead_band)) ? CENTRE_US : w;
    endfunction

    function automatic int scale_width(input int w, input int mul);
        int c;
        c = (w < RAW_MIN_US) ? RAW_MIN_US : (w > RAW_MAX_US) ? RAW_MAX_US : w;
        return ((c - RAW_MIN_US) * mul + ROUND_BIAS) / 25;
    endfunction

    function automatic cmd_t map_commands();
        cmd_t c;
        c.roll  = ROLL_W'(scale_width(snap_centre(int'(chan_us[0])), MUL_RP) - OFS_RP);
        c.pitch = PITCH_W'(scale_width(snap_centre(int'(chan_us[1])), MUL_RP) - OFS_RP);
        c.thr   = THR_W'(scale_width(int'(chan_us[2]), MUL_THR));
        c.yaw   = YAW_W'(scale_width(snap_centre(int'(chan_us[3])), MUL_YAW) - OFS_YAW);
        c.armed = (chan_us[6] >= arm_level);
        return c;
    endfunction

    task automatic report_fault(input string what, input longint want, input longint got);
        faults++;
        if (faults <= 10)
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Sink: check each accepted command item against the oldest prediction
    always @(posedge clk)
    begin : check_cmds
        cmd_t got;
        cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[OUT_FIELD_W-1:0];
            if (pending_cmds.size() == 0)
                report_fault("command item with none pending", 0, 1);
            else
            begin
                want = pending_cmds.pop_front();
                cmds_checked++;
                if (got.roll !== want.roll)
                    report_fault("roll_cmd", $signed(want.roll), $signed(got.roll));
                if (got.pitch !== want.pitch)
                    report_fault("pitch_cmd", $signed(want.pitch), $signed(got.pitch));
                if (got.thr !== want.thr)
                    report_fault("throttle_cmd", want.thr, got.thr);
                if (got.yaw !== want.yaw)
                    report_fault("yaw_rate_cmd", $signed(want.yaw), $signed(got.yaw));
                if (got.armed !== want.armed)
                    report_fault("armed", want.armed, got.armed);
                if (m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W] !== '0)
                    report_fault("tdata pad", 0, m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W]);
            end
            sink_wait = rush ? 0 : $urandom_range(0, 19);
        end
    end

    // Hold tready low for the drawn number of cycles after each item
    always @(negedge clk)
    begin
        if (sink_wait > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_wait = sink_wait - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d commands pending",
                     cycle_count, pending_cmds.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic req, input logic [15:0] cap, input logic [15:0] tick);
        int hold;
        hold = rush ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (hold > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (hold) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {tick, cap};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (req == REQ_EDGE)
        begin
            ppm_edge_update(cap, tick);
            cap_now  = cap;
            tick_now = tick;
        end
        else
        begin
            reads_sent++;
            pending_cmds.push_back(map_commands());
        end
    endtask

    task automatic send_edge(input int width, input int dtick);
        send_item(REQ_EDGE, cap_now + 16'(width), tick_now + 16'(dtick));
    endtask

    task automatic read_cmds();
        send_item(REQ_READ, 16'($urandom), 16'($urandom));
    endtask

    // Drop valid, drain results, then let the last edge settle
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_VALID_MIN: win_lo     = 12'(value);
            CFG_VALID_MAX: win_hi     = 12'(value);
            CFG_SYNC_GAP:  sync_limit = 16'(value);
            CFG_DEADBAND:  dead_band  = 9'(value);
            CFG_ARM_THR:   arm_level  = 12'(value);
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int vmin, input int vmax, input int sync,
                                  input int db, input int arm);
        settle();
        write_reg(CFG_VALID_MIN, vmin);
        write_reg(CFG_VALID_MAX, vmax);
        write_reg(CFG_SYNC_GAP, sync);
        write_reg(CFG_DEADBAND, db);
        write_reg(CFG_ARM_THR, arm);
        settings_used++;
    endtask

    // One frame: sync edge, a run of channel edges, reads in between and at the end
    task automatic send_frame();
        int n;
        int w;
        int pick;
        int dtick;
        int span;
        span = int'(sync_limit) / US_PER_MS;
        send_edge($urandom_range(0, 65535), span + 1 + $urandom_range(0, 3));
        n = $urandom_range(3, 11);
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                w = $urandom_range(900, 2100);
            else if (pick < 80)
            begin
                w = ($urandom_range(0, 1) ? int'(win_lo) : int'(win_hi))
                    + $urandom_range(0, 4) - 2;
                if (w < 0)
                    w = 0;
            end
            else if (pick < 90)
                w = CENTRE_US + ($urandom_range(0, 1) ? 1 : -1)
                    * (int'(dead_band) + $urandom_range(0, 1));
            else
                w = $urandom_range(0, 65535);
            // occasionally break the frame with a long tick gap
            dtick = ($urandom_range(0, 29) == 0) ? span + 1 : $urandom_range(0, span);
            send_edge(w, dtick);
            if ($urandom_range(0, 7) == 0)
                read_cmds();
        end
        read_cmds();
    endtask

    task automatic test_reset_state();
        read_cmds();
    endtask

    task automatic test_frame_extremes();
        send_edge(65000, 100);
        send_edge(990, 0);      // wraps the timer, lowest valid width
        send_edge(2010, 1);
        send_edge(989, 0);      // below window: keep old width
        send_edge(2011, 2);     // above window, tick gap just under sync
        send_edge(1500, 0);
        send_edge(1200, 0);
        send_edge(1500, 0);     // armed exactly at threshold
        send_edge(1800, 0);
        send_edge(1000, 0);     // past the last channel
        send_edge(1000, 0);
        read_cmds();
        send_edge(3000, 65535 - int'(tick_now));
        send_edge(1550, 0);     // edge of deadband: snap
        send_edge(1449, 0);     // just outside deadband
        send_edge(2000, 0);
        send_edge(1700, 4);     // tick wraps; width stored, then frame restarts
        send_edge(1450, 0);
        read_cmds();
    endtask

    task automatic test_settings_sweep();
        int vals [6][5] = '{
            '{990, 2010, 2010, 50, 1500},
            '{0, 4095, 0, 0, 0},
            '{4095, 4095, 65535, 500, 4095},
            '{2000, 1000, 2010, 511, 1000},
            '{1000, 2000, 3000, 100, 2000},
            '{0, 0, 65535, 1, 1}
        };
        foreach (vals[s])
        begin
            apply_settings(vals[s][0], vals[s][1], vals[s][2], vals[s][3], vals[s][4]);
            repeat (5)
                send_frame();
        end
    endtask

    task automatic test_random_traffic();
        int start;
        int next_cfg;
        start = items_sent;
        next_cfg = start + 400;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (items_sent >= next_cfg)
            begin
                apply_settings($urandom_range(0, 1100), $urandom_range(1900, 4095),
                               $urandom_range(0, 65535), $urandom_range(0, 511),
                               $urandom_range(0, 4095));
                next_cfg = items_sent + 400;
            end
            if ($urandom_range(0, 3) == 0)
                rush = ~rush;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 6))
                    send_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
            else
                send_frame();
        end
        rush = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        settings_used = 1;

        test_reset_state();
        test_frame_extremes();
        test_settings_sweep();
        test_random_traffic();

        settle();
        repeat (10) @(posedge clk);
        if (pending_cmds.size() != 0)
            report_fault("commands never delivered", 0, pending_cmds.size());

        $display("Sent %0d items (%0d reads) over %0d register settings,",
                 items_sent, reads_sent, settings_used);
        $display("checked %0d command items, %0d faults", cmds_checked, faults);
        if (faults == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
